// ===== design/svgpf_pkg.sv =====
`timescale 1ns / 1ps

package svgpf_pkg;

    localparam int MAX_POLYGONS = 16;
    localparam logic [3:0] POLY_TOP = 4'((MAX_POLYGONS - 1 < 15) ? MAX_POLYGONS - 1 : 15);

    localparam logic [3:0] OP_M      = 4'd0;
    localparam logic [3:0] OP_L      = 4'd1;
    localparam logic [3:0] OP_L_REL  = 4'd2;
    localparam logic [3:0] OP_H      = 4'd3;
    localparam logic [3:0] OP_H_REL  = 4'd4;
    localparam logic [3:0] OP_V      = 4'd5;
    localparam logic [3:0] OP_V_REL  = 4'd6;
    localparam logic [3:0] OP_C      = 4'd7;
    localparam logic [3:0] OP_C_REL  = 4'd8;
    localparam logic [3:0] OP_S      = 4'd9;
    localparam logic [3:0] OP_S_REL  = 4'd10;
    localparam logic [3:0] OP_Z      = 4'd11;

    localparam logic signed [31:0] COORD_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] COORD_MIN = 32'sh80000000;

    typedef struct packed {
        logic [3:0]         operation;
        logic               path_start;
        logic signed [31:0] arg0;
        logic signed [31:0] arg1;
        logic signed [31:0] arg2;
        logic signed [31:0] arg3;
        logic signed [31:0] arg4;
        logic signed [31:0] arg5;
        logic [7:0]         glyph;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [3:0]         polygon;
        logic [7:0]         glyph_out;
        logic               last;
        logic               status;
    } point_t;

    typedef enum logic [1:0] {
        KIND_SET,
        KIND_CURVE,
        KIND_CLOSE,
        KIND_NONE
    } kind_t;

    // Classified command. For moves and lines the target sits in the end slot;
    // for smooth curves the first control slot is unused.
    typedef struct packed {
        kind_t              kind;
        logic               rel;
        logic               smooth;
        logic               upd_x;
        logic               upd_y;
        logic               path_start;
        logic [7:0]         glyph;
        logic signed [31:0] c0_x;
        logic signed [31:0] c0_y;
        logic signed [31:0] c1_x;
        logic signed [31:0] c1_y;
        logic signed [31:0] e_x;
        logic signed [31:0] e_y;
    } entry_t;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31])
            return s[32] ? COORD_MIN : COORD_MAX;
        return s[31:0];
    endfunction

    // Reflection of a control point about an end point: 2*e - c, saturated.
    function automatic logic signed [31:0] reflect(input logic signed [31:0] e,
                                                   input logic signed [31:0] c);
        logic signed [33:0] t;
        t = (34'(e) <<< 1) - 34'(c);
        if (!((t[33:31] == 3'b000) || (t[33:31] == 3'b111)))
            return t[33] ? COORD_MIN : COORD_MAX;
        return t[31:0];
    endfunction

    // Cubic point at t = 1/2: (s + 3*c0 + 3*c1 + e) / 8, rounded toward minus infinity.
    function automatic logic signed [31:0] midpoint(input logic signed [31:0] s,
                                                    input logic signed [31:0] c0,
                                                    input logic signed [31:0] c1,
                                                    input logic signed [31:0] e);
        logic signed [35:0] q;
        logic signed [35:0] sum;
        q = 36'(c0) + 36'(c1);
        sum = 36'(s) + 36'(e) + (q <<< 1) + q;
        return sum[34:3];
    endfunction

    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] y);
        return (y == COORD_MIN) ? COORD_MAX : -y;
    endfunction

endpackage

// ===== design/svgpf_front.sv =====
`timescale 1ns / 1ps

module svgpf_front
    import svgpf_pkg::*;
(
    input  logic   cmd_valid,
    output logic   cmd_ready,
    input  cmd_t   cmd,
    output logic   entry_valid,
    input  logic   entry_ready,
    output entry_t entry
);

    assign entry_valid = cmd_valid;
    assign cmd_ready   = entry_ready;

    always_comb
    begin
        entry            = '0;
        entry.kind       = KIND_NONE;
        entry.path_start = cmd.path_start;
        entry.glyph      = cmd.glyph;
        case (cmd.operation)
            OP_M, OP_L, OP_L_REL:
            begin
                entry.kind  = KIND_SET;
                entry.rel   = (cmd.operation == OP_L_REL);
                entry.upd_x = 1'b1;
                entry.upd_y = 1'b1;
                entry.e_x   = cmd.arg0;
                entry.e_y   = cmd.arg1;
            end
            OP_H, OP_H_REL:
            begin
                entry.kind  = KIND_SET;
                entry.rel   = (cmd.operation == OP_H_REL);
                entry.upd_x = 1'b1;
                entry.e_x   = cmd.arg0;
            end
            OP_V, OP_V_REL:
            begin
                entry.kind  = KIND_SET;
                entry.rel   = (cmd.operation == OP_V_REL);
                entry.upd_y = 1'b1;
                entry.e_y   = cmd.arg0;
            end
            OP_C, OP_C_REL:
            begin
                entry.kind = KIND_CURVE;
                entry.rel  = (cmd.operation == OP_C_REL);
                entry.c0_x = cmd.arg0;
                entry.c0_y = cmd.arg1;
                entry.c1_x = cmd.arg2;
                entry.c1_y = cmd.arg3;
                entry.e_x  = cmd.arg4;
                entry.e_y  = cmd.arg5;
            end
            OP_S, OP_S_REL:
            begin
                entry.kind   = KIND_CURVE;
                entry.rel    = (cmd.operation == OP_S_REL);
                entry.smooth = 1'b1;
                entry.c1_x   = cmd.arg0;
                entry.c1_y   = cmd.arg1;
                entry.e_x    = cmd.arg2;
                entry.e_y    = cmd.arg3;
            end
            OP_Z:
            begin
                entry.kind = KIND_CLOSE;
            end
            default:
            begin
                entry.kind = KIND_NONE;
            end
        endcase
    end

endmodule

// ===== design/svgpf_queue.sv =====
`timescale 1ns / 1ps

module svgpf_queue
    import svgpf_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  entry_t push_entry,
    output logic   pop_valid,
    input  logic   pop,
    output entry_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg < CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== design/svgpf_back.sv =====
`timescale 1ns / 1ps

module svgpf_back
    import svgpf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   head_valid,
    output logic   head_pop,
    input  entry_t head,
    output logic   point_valid,
    input  logic   point_ready,
    output point_t point
);

    typedef enum logic [1:0] {
        ST_EXEC,
        ST_MID,
        ST_END,
        ST_LAST
    } state_t;

    state_t             state_reg, state_next;
    logic signed [31:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [31:0] rend_x_reg, rend_x_next, rend_y_reg, rend_y_next;
    logic signed [31:0] rctl_x_reg, rctl_x_next, rctl_y_reg, rctl_y_next;
    logic               prev_curve_reg, prev_curve_next;
    logic               first_cmd_reg, first_cmd_next;
    logic [3:0]         poly_reg, poly_next;
    logic signed [31:0] s_x_reg, s_x_next, s_y_reg, s_y_next;
    logic signed [31:0] c0_x_reg, c0_x_next, c0_y_reg, c0_y_next;
    logic signed [31:0] c1_x_reg, c1_x_next, c1_y_reg, c1_y_next;
    logic signed [31:0] e_x_reg, e_x_next, e_y_reg, e_y_next;
    logic               status_reg, status_next;
    logic [7:0]         glyph_reg, glyph_next;
    logic               pt_valid_reg, pt_valid_next;
    point_t             pt_reg, pt_next;

    logic               can_load;
    logic               emits;
    logic               ps;
    logic signed [31:0] base_x, base_y, rel_x, rel_y;
    logic               prev_eff, first_eff;
    logic [3:0]         poly_eff;
    logic signed [31:0] abs_c0_x, abs_c0_y, abs_c1_x, abs_c1_y, abs_e_x, abs_e_y;
    logic signed [31:0] set_x, set_y;
    logic signed [31:0] ctl0_x, ctl0_y;
    logic               smooth_orphan;

    assign can_load = !pt_valid_reg || point_ready;
    assign emits    = (head.kind == KIND_SET) || (head.kind == KIND_CURVE);
    assign head_pop = (state_reg == ST_EXEC) && head_valid && (can_load || !emits);

    // A path start clears the path state ahead of the command that carries it.
    assign ps        = head.path_start;
    assign base_x    = ps ? '0 : cur_x_reg;
    assign base_y    = ps ? '0 : cur_y_reg;
    assign prev_eff  = ps ? 1'b0 : prev_curve_reg;
    assign first_eff = ps ? 1'b1 : first_cmd_reg;
    assign poly_eff  = ps ? '0 : poly_reg;
    assign rel_x     = head.rel ? base_x : '0;
    assign rel_y     = head.rel ? base_y : '0;

    assign abs_c0_x = sat_add(rel_x, head.c0_x);
    assign abs_c0_y = sat_add(rel_y, head.c0_y);
    assign abs_c1_x = sat_add(rel_x, head.c1_x);
    assign abs_c1_y = sat_add(rel_y, head.c1_y);
    assign abs_e_x  = sat_add(rel_x, head.e_x);
    assign abs_e_y  = sat_add(rel_y, head.e_y);

    assign set_x = head.upd_x ? abs_e_x : base_x;
    assign set_y = head.upd_y ? abs_e_y : base_y;

    assign smooth_orphan = head.smooth && !prev_eff;

    always_comb
    begin
        if (!head.smooth)
        begin
            ctl0_x = abs_c0_x;
            ctl0_y = abs_c0_y;
        end
        else if (prev_eff)
        begin
            ctl0_x = reflect(rend_x_reg, rctl_x_reg);
            ctl0_y = reflect(rend_y_reg, rctl_y_reg);
        end
        else
        begin
            ctl0_x = '0;
            ctl0_y = '0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        rend_x_next     = rend_x_reg;
        rend_y_next     = rend_y_reg;
        rctl_x_next     = rctl_x_reg;
        rctl_y_next     = rctl_y_reg;
        prev_curve_next = prev_curve_reg;
        first_cmd_next  = first_cmd_reg;
        poly_next       = poly_reg;
        s_x_next        = s_x_reg;
        s_y_next        = s_y_reg;
        c0_x_next       = c0_x_reg;
        c0_y_next       = c0_y_reg;
        c1_x_next       = c1_x_reg;
        c1_y_next       = c1_y_reg;
        e_x_next        = e_x_reg;
        e_y_next        = e_y_reg;
        status_next     = status_reg;
        glyph_next      = glyph_reg;
        pt_valid_next   = pt_valid_reg && !point_ready;
        pt_next         = pt_reg;

        case (state_reg)
            ST_EXEC:
            begin
                if (head_pop)
                begin
                    cur_x_next      = base_x;
                    cur_y_next      = base_y;
                    rend_x_next     = ps ? '0 : rend_x_reg;
                    rend_y_next     = ps ? '0 : rend_y_reg;
                    rctl_x_next     = ps ? '0 : rctl_x_reg;
                    rctl_y_next     = ps ? '0 : rctl_y_reg;
                    prev_curve_next = prev_eff;
                    first_cmd_next  = first_eff;
                    poly_next       = poly_eff;
                    case (head.kind)
                        KIND_SET:
                        begin
                            cur_x_next      = set_x;
                            cur_y_next      = set_y;
                            prev_curve_next = 1'b0;
                            first_cmd_next  = 1'b0;
                            pt_valid_next   = 1'b1;
                            pt_next         = '{point_x: set_x, point_y: neg_sat(set_y),
                                                polygon: poly_eff, glyph_out: head.glyph,
                                                last: 1'b1, status: 1'b0};
                        end
                        KIND_CLOSE:
                        begin
                            prev_curve_next = 1'b0;
                            first_cmd_next  = 1'b0;
                            if (poly_eff < POLY_TOP)
                                poly_next = poly_eff + 1'b1;
                        end
                        KIND_CURVE:
                        begin
                            rend_x_next     = abs_e_x;
                            rend_y_next     = abs_e_y;
                            rctl_x_next     = abs_c1_x;
                            rctl_y_next     = abs_c1_y;
                            prev_curve_next = 1'b1;
                            first_cmd_next  = 1'b0;
                            pt_valid_next   = 1'b1;
                            if (head.smooth && first_eff)
                            begin
                                // Smooth curve opening a path: only the current point.
                                pt_next = '{point_x: base_x, point_y: neg_sat(base_y),
                                            polygon: poly_eff, glyph_out: head.glyph,
                                            last: 1'b1, status: 1'b0};
                            end
                            else
                            begin
                                cur_x_next  = abs_e_x;
                                cur_y_next  = abs_e_y;
                                s_x_next    = base_x;
                                s_y_next    = base_y;
                                c0_x_next   = ctl0_x;
                                c0_y_next   = ctl0_y;
                                c1_x_next   = abs_c1_x;
                                c1_y_next   = abs_c1_y;
                                e_x_next    = abs_e_x;
                                e_y_next    = abs_e_y;
                                status_next = smooth_orphan;
                                glyph_next  = head.glyph;
                                state_next  = ST_MID;
                                pt_next     = '{point_x: base_x, point_y: neg_sat(base_y),
                                                polygon: poly_eff, glyph_out: head.glyph,
                                                last: 1'b0, status: smooth_orphan};
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MID:
            begin
                if (can_load)
                begin
                    pt_valid_next = 1'b1;
                    pt_next       = '{point_x: midpoint(s_x_reg, c0_x_reg, c1_x_reg, e_x_reg),
                                      point_y: neg_sat(midpoint(s_y_reg, c0_y_reg,
                                                                c1_y_reg, e_y_reg)),
                                      polygon: poly_reg, glyph_out: glyph_reg,
                                      last: 1'b0, status: status_reg};
                    state_next    = ST_END;
                end
            end
            ST_END, ST_LAST:
            begin
                if (can_load)
                begin
                    pt_valid_next = 1'b1;
                    pt_next       = '{point_x: e_x_reg, point_y: neg_sat(e_y_reg),
                                      polygon: poly_reg, glyph_out: glyph_reg,
                                      last: (state_reg == ST_LAST), status: status_reg};
                    state_next    = (state_reg == ST_LAST) ? ST_EXEC : ST_LAST;
                end
            end
            default:
            begin
                state_next = ST_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_EXEC;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            rend_x_reg     <= '0;
            rend_y_reg     <= '0;
            rctl_x_reg     <= '0;
            rctl_y_reg     <= '0;
            prev_curve_reg <= 1'b0;
            first_cmd_reg  <= 1'b1;
            poly_reg       <= '0;
            s_x_reg        <= '0;
            s_y_reg        <= '0;
            c0_x_reg       <= '0;
            c0_y_reg       <= '0;
            c1_x_reg       <= '0;
            c1_y_reg       <= '0;
            e_x_reg        <= '0;
            e_y_reg        <= '0;
            status_reg     <= 1'b0;
            glyph_reg      <= '0;
            pt_valid_reg   <= 1'b0;
            pt_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            rend_x_reg     <= rend_x_next;
            rend_y_reg     <= rend_y_next;
            rctl_x_reg     <= rctl_x_next;
            rctl_y_reg     <= rctl_y_next;
            prev_curve_reg <= prev_curve_next;
            first_cmd_reg  <= first_cmd_next;
            poly_reg       <= poly_next;
            s_x_reg        <= s_x_next;
            s_y_reg        <= s_y_next;
            c0_x_reg       <= c0_x_next;
            c0_y_reg       <= c0_y_next;
            c1_x_reg       <= c1_x_next;
            c1_y_reg       <= c1_y_next;
            e_x_reg        <= e_x_next;
            e_y_reg        <= e_y_next;
            status_reg     <= status_next;
            glyph_reg      <= glyph_next;
            pt_valid_reg   <= pt_valid_next;
            pt_reg         <= pt_next;
        end
    end

    assign point_valid = pt_valid_reg;
    assign point       = pt_reg;

endmodule

// ===== design/svg_path_flattener_top.sv =====
// The first point of a request passes through the queue and then the output register.
// Moves and lines give one point each; a curve holds the executing sequencer through states
// EXEC, MID, END, LAST (start, midpoint, end, end), one point per cycle while not stalled;
// a smooth curve opening a path gives only its start; close and unknown requests give none.
// Reset: rst_n clears the queue, the output register and the path state at once.
`timescale 1ns / 1ps

module svg_path_flattener_top
    import svgpf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cmd_valid,
    output logic   cmd_ready,
    input  cmd_t   cmd,
    output logic   point_valid,
    input  logic   point_ready,
    output point_t point
);

    logic   fe_valid;
    logic   fe_ready;
    entry_t fe_entry;
    logic   head_valid;
    logic   head_pop;
    entry_t head;

    svgpf_front u_front (
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .entry_valid (fe_valid),
        .entry_ready (fe_ready),
        .entry       (fe_entry)
    );

    svgpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_entry (fe_entry),
        .pop_valid  (head_valid),
        .pop        (head_pop),
        .pop_entry  (head)
    );

    svgpf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_pop    (head_pop),
        .head        (head),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point)
    );

endmodule
